>>> hw/rtl/tlfq_pkg.sv
// shared types, constants and helpers for the three-level feedback queue scheduler
package tlfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int LEVELS      = 3;

    localparam int HEAD_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(LEVELS * QUEUE_DEPTH);
    localparam int JOB_W  = 32;
    localparam int MEM_DEPTH = LEVELS * QUEUE_DEPTH;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SLICE0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXPEN0  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXPEN1  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXPEN2  = 3'd6;

    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_STEP   = 1'b1;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_REFUSED  = 2'd1;
    localparam logic [1:0] ST_RAN      = 2'd2;
    localparam logic [1:0] ST_IDLE     = 2'd3;

    localparam logic [1:0] LVL0 = 2'd0;
    localparam logic [1:0] LVL1 = 2'd1;
    localparam logic [1:0] LVL2 = 2'd2;

    typedef struct packed {
        logic [7:0]  pen;
        logic [15:0] work;
        logic [7:0]  id;
    } job_t;

    typedef struct packed {
        logic [31:0] time_now;
        logic [1:0]  next_level;
        logic        moved;
        logic        finished;
        logic [7:0]  penalty_after;
        logic [15:0] remaining;
        logic [1:0]  ran_level;
        logic [7:0]  ran_id;
    } result_t;

    function automatic logic [ADDR_W-1:0] level_base(input logic [1:0] lv);
        logic [ADDR_W-1:0] base;
        unique case (lv)
            LVL0:    base = '0;
            LVL1:    base = ADDR_W'(QUEUE_DEPTH);
            default: base = ADDR_W'(2 * QUEUE_DEPTH);
        endcase
        return base;
    endfunction

    function automatic logic [HEAD_W-1:0] tail_slot(input logic [HEAD_W-1:0] head,
                                                     input logic [CNT_W-1:0] count);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(count);
        if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return sum[HEAD_W-1:0];
    endfunction

    function automatic logic [HEAD_W-1:0] next_head(input logic [HEAD_W-1:0] head);
        logic [HEAD_W:0] sum;
        sum = (HEAD_W + 1)'(head) + (HEAD_W + 1)'(1);
        if (sum >= (HEAD_W + 1)'(QUEUE_DEPTH)) begin
            sum = '0;
        end
        return sum[HEAD_W-1:0];
    endfunction

endpackage

>>> hw/rtl/tlfq_ram.sv
// generic simple dual-port ram with registered read
module tlfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/three_level_feedback_queue_scheduler_unit.sv
// top level of the three-level feedback queue scheduler
//
// input channel s_*: one transaction is either an arrival (job id and size
// go to the tail of level 0) or a scheduling step (the head of the highest
// non-empty level runs one slice). every input transaction gives exactly one
// result transaction on m_*, whose tuser carries the status code.
// config channel cfg_*: always ready; writes slices, penalty gain and the
// penalty limits, and is meant to be used while the unit is idle.
// arrivals and steps on an empty scheduler write their result into the
// output register on acceptance; a step that runs a job first reads the job
// from memory, then updates it, writes it back and registers the result.
// one arrival per cycle while the receiver keeps up; a step that runs a job
// holds off new input until its write-back, as the single job memory port pair reads first.
// reset (synchronous, active low) empties all levels, clears time and loads
// the default config; job memory contents are not cleared.
// when the receiver stalls, the finished result waits in the output register
// and one more input transaction is taken only as that register drains.
module three_level_feedback_queue_scheduler_unit
    import tlfq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // job_id, job_size
    input  logic [0:0]           s_tuser,   // action
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,   // ran_id, ran_level, remaining, penalty_after,
                                            // finished, moved, next_level, time_now
    output logic [1:0]           m_tuser,   // status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic              state_reg, state_next;
    logic [1:0]        run_level_reg, run_level_next;
    logic [HEAD_W-1:0] level_head_reg [LEVELS];
    logic [HEAD_W-1:0] level_head_next [LEVELS];
    logic [CNT_W-1:0]  level_count_reg [LEVELS];
    logic [CNT_W-1:0]  level_count_next [LEVELS];
    logic [CNT_W-1:0]  jobs_held_reg, jobs_held_next;
    logic [31:0]       time_reg, time_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    result_t           out_reg, out_next;

    logic [7:0] slice_reg [LEVELS];
    logic [7:0] maxpen_reg [LEVELS];
    logic [7:0] gain_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    job_t              mem_wdata;
    logic [JOB_W-1:0]  mem_rdata;

    logic              in_fire;
    logic [7:0]        in_id;
    logic [15:0]       in_size;
    logic [1:0]        pick_level;
    logic              any_job;

    job_t              run_job;
    logic [7:0]        run_slice;
    logic [15:0]       work_new;
    logic [8:0]        pen_sum;
    logic              fin;
    logic              move;
    logic [1:0]        move_level;
    logic [1:0]        push_level;

    tlfq_ram #(
        .WIDTH(JOB_W),
        .DEPTH(MEM_DEPTH)
    ) u_job_ram (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign in_fire   = s_tvalid && s_tready;
    assign in_id     = s_tdata[7:0];
    assign in_size   = s_tdata[23:8];

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_reg};

    always_comb begin
        any_job = 1'b1;
        priority if (level_count_reg[0] != '0) begin
            pick_level = LVL0;
        end else if (level_count_reg[1] != '0) begin
            pick_level = LVL1;
        end else if (level_count_reg[2] != '0) begin
            pick_level = LVL2;
        end else begin
            pick_level = LVL0;
            any_job    = 1'b0;
        end
    end

    assign mem_raddr = level_base(pick_level) + ADDR_W'(level_head_reg[pick_level]);

    always_comb begin
        run_job   = job_t'(mem_rdata);
        run_slice = slice_reg[run_level_reg];
        work_new  = (run_job.work > 16'(run_slice)) ? run_job.work - 16'(run_slice) : '0;
        pen_sum   = 9'(run_job.pen) + 9'(gain_reg);
        fin       = (work_new == '0);
        move      = (pen_sum >= 9'(maxpen_reg[run_level_reg]));
        move_level = (run_level_reg == LVL2) ? LVL0 : run_level_reg + 2'd1;
        push_level = move ? move_level : run_level_reg;
    end

    always_comb begin
        state_next     = state_reg;
        run_level_next = run_level_reg;
        for (int i = 0; i < LEVELS; i++) begin
            level_head_next[i]  = level_head_reg[i];
            level_count_next[i] = level_count_reg[i];
        end
        jobs_held_next  = jobs_held_reg;
        time_next       = time_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (s_tuser[0] == ACT_ARRIVE) begin
                        out_valid_next = 1'b1;
                        out_next       = '0;
                        out_next.ran_id    = in_id;
                        out_next.remaining = in_size;
                        out_next.time_now  = time_reg;
                        if (jobs_held_reg >= CNT_W'(QUEUE_DEPTH)) begin
                            out_status_next = ST_REFUSED;
                        end else begin
                            out_status_next = ST_ACCEPTED;
                            mem_we    = 1'b1;
                            mem_waddr = level_base(LVL0) +
                                        ADDR_W'(tail_slot(level_head_reg[0], level_count_reg[0]));
                            mem_wdata.id   = in_id;
                            mem_wdata.work = in_size;
                            mem_wdata.pen  = '0;
                            level_count_next[0] = level_count_reg[0] + CNT_W'(1);
                            jobs_held_next      = jobs_held_reg + CNT_W'(1);
                        end
                    end else if (!any_job) begin
                        time_next       = time_reg + 32'd1;
                        out_valid_next  = 1'b1;
                        out_status_next = ST_IDLE;
                        out_next          = '0;
                        out_next.time_now = time_reg + 32'd1;
                    end else begin
                        // pop the head now, the job comes back from memory next cycle
                        level_head_next[pick_level]  = next_head(level_head_reg[pick_level]);
                        level_count_next[pick_level] = level_count_reg[pick_level] - CNT_W'(1);
                        run_level_next = pick_level;
                        state_next     = S_RUN;
                    end
                end
            end
            default: begin
                state_next      = S_IDLE;
                time_next       = time_reg + 32'(run_slice);
                out_valid_next  = 1'b1;
                out_status_next = ST_RAN;
                out_next.ran_id     = run_job.id;
                out_next.ran_level  = run_level_reg;
                out_next.remaining  = work_new;
                out_next.finished   = fin;
                out_next.moved      = !fin && move;
                out_next.time_now   = time_reg + 32'(run_slice);
                if (fin) begin
                    jobs_held_next         = jobs_held_reg - CNT_W'(1);
                    out_next.penalty_after = pen_sum[8] ? 8'hff : pen_sum[7:0];
                    out_next.next_level    = LVL0;
                end else begin
                    out_next.penalty_after = move ? 8'd0 : pen_sum[7:0];
                    out_next.next_level    = push_level;
                    mem_we    = 1'b1;
                    mem_waddr = level_base(push_level) +
                                ADDR_W'(tail_slot(level_head_reg[push_level],
                                                  level_count_reg[push_level]));
                    mem_wdata.id   = run_job.id;
                    mem_wdata.work = work_new;
                    mem_wdata.pen  = move ? 8'd0 : pen_sum[7:0];
                    level_count_next[push_level] = level_count_reg[push_level] + CNT_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            run_level_reg <= LVL0;
            for (int i = 0; i < LEVELS; i++) begin
                level_head_reg[i]  <= '0;
                level_count_reg[i] <= '0;
            end
            jobs_held_reg  <= '0;
            time_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_ACCEPTED;
            slice_reg[0]   <= 8'd1;
            slice_reg[1]   <= 8'd1;
            slice_reg[2]   <= 8'd1;
            gain_reg       <= 8'd1;
            maxpen_reg[0]  <= 8'd2;
            maxpen_reg[1]  <= 8'd2;
            maxpen_reg[2]  <= 8'd4;
        end else begin
            state_reg     <= state_next;
            run_level_reg <= run_level_next;
            for (int i = 0; i < LEVELS; i++) begin
                level_head_reg[i]  <= level_head_next[i];
                level_count_reg[i] <= level_count_next[i];
            end
            jobs_held_reg  <= jobs_held_next;
            time_reg       <= time_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_SLICE0:  slice_reg[0]  <= cfg_data;
                    CFG_SLICE1:  slice_reg[1]  <= cfg_data;
                    CFG_SLICE2:  slice_reg[2]  <= cfg_data;
                    CFG_GAIN:    gain_reg      <= cfg_data;
                    CFG_MAXPEN0: maxpen_reg[0] <= cfg_data;
                    CFG_MAXPEN1: maxpen_reg[1] <= cfg_data;
                    CFG_MAXPEN2: maxpen_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule

>>> sim/tb_top.sv
// self-checking testbench for the three-level feedback queue scheduler unit
module tb_top
    import tlfq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    localparam int SETTLE      = 8;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic        act;
        logic [7:0]  id;
        logic [15:0] size;
    } sched_req_t;

    typedef struct packed {
        logic [1:0] status;
        result_t    res;
    } sched_out_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata   = '0;   // job_id, job_size
    logic [0:0]           s_tuser   = '0;   // action
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [71:0]          m_tdata;          // ran_id, ran_level, remaining, penalty_after,
                                            // finished, moved, next_level, time_now
    logic [1:0]           m_tuser;          // status
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    // scheduler state as predicted
    job_t        job_mem [LEVELS][QUEUE_DEPTH];
    int unsigned lvl_head [LEVELS]  = '{0, 0, 0};
    int unsigned lvl_count [LEVELS] = '{0, 0, 0};
    int unsigned jobs_held          = 0;
    logic [31:0] sched_clock        = '0;
    logic [7:0]  slice_cfg [LEVELS] = '{8'd1, 8'd1, 8'd1};
    logic [7:0]  gain_cfg           = 8'd1;
    logic [7:0]  limit_cfg [LEVELS] = '{8'd2, 8'd2, 8'd4};

    sched_req_t pending_q[$];
    sched_out_t expected_q[$];
    sched_req_t cur_req;
    logic       in_fire      = 1'b0;
    int         tx_idle_pct  = 0;
    int         rx_idle_pct  = 0;
    int         mismatches   = 0;
    int         quiet_cycles = 0;

    three_level_feedback_queue_scheduler_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic void enqueue_job(input int lv, input job_t j);
        job_mem[lv][(lvl_head[lv] + lvl_count[lv]) % QUEUE_DEPTH] = j;
        lvl_count[lv]++;
    endfunction

    function automatic sched_out_t schedule_item(input sched_req_t req);
        sched_out_t o;
        job_t       j;
        int         lv;
        logic [8:0] pen_sum;
        logic [7:0] sl;
        o = '0;
        if (req.act == ACT_ARRIVE) begin
            o.res.ran_id    = req.id;
            o.res.remaining = req.size;
            if (jobs_held >= QUEUE_DEPTH) begin
                o.status = ST_REFUSED;
            end else begin
                j.id   = req.id;
                j.work = req.size;
                j.pen  = '0;
                enqueue_job(0, j);
                jobs_held++;
                o.status = ST_ACCEPTED;
            end
            o.res.time_now = sched_clock;
            return o;
        end
        lv = 0;
        while (lv < LEVELS && lvl_count[lv] == 0) lv++;
        if (lv == LEVELS) begin
            sched_clock    = sched_clock + 32'd1;
            o.status       = ST_IDLE;
            o.res.time_now = sched_clock;
            return o;
        end
        j = job_mem[lv][lvl_head[lv]];
        lvl_head[lv] = (lvl_head[lv] + 1) % QUEUE_DEPTH;
        lvl_count[lv]--;
        sl      = slice_cfg[lv];
        pen_sum = {1'b0, j.pen} + {1'b0, gain_cfg};
        j.work  = (j.work > sl) ? j.work - sl : 16'd0;
        o.status        = ST_RAN;
        o.res.ran_id    = j.id;
        o.res.ran_level = 2'(lv);
        o.res.remaining = j.work;
        if (j.work == 16'd0) begin
            jobs_held--;
            o.res.penalty_after = (pen_sum > 9'd255) ? 8'd255 : pen_sum[7:0];
            o.res.finished      = 1'b1;
        end else if (pen_sum >= {1'b0, limit_cfg[lv]}) begin
            j.pen = '0;
            enqueue_job((lv + 1) % LEVELS, j);
            o.res.moved      = 1'b1;
            o.res.next_level = 2'((lv + 1) % LEVELS);
        end else begin
            j.pen = pen_sum[7:0];
            enqueue_job(lv, j);
            o.res.penalty_after = pen_sum[7:0];
            o.res.next_level    = 2'(lv);
        end
        sched_clock    = sched_clock + 32'(sl);
        o.res.time_now = sched_clock;
        return o;
    endfunction

    // input side: predict on each accepted transaction, track config writes
    always @(posedge aclk) begin
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            expected_q.push_back(schedule_item(cur_req));
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SLICE0:  slice_cfg[0] = cfg_data;
                CFG_SLICE1:  slice_cfg[1] = cfg_data;
                CFG_SLICE2:  slice_cfg[2] = cfg_data;
                CFG_GAIN:    gain_cfg     = cfg_data;
                CFG_MAXPEN0: limit_cfg[0] = cfg_data;
                CFG_MAXPEN1: limit_cfg[1] = cfg_data;
                CFG_MAXPEN2: limit_cfg[2] = cfg_data;
                default: ;
            endcase
        end
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_fire)) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                cur_req = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {cur_req.size, cur_req.id};
                s_tuser  <= cur_req.act;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        sched_out_t got;
        sched_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.res    = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected result transaction, status %0d id %0d",
                             $realtime, got.status, got.res.ran_id);
                end
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: mismatch exp/act status %0d/%0d id %0d/%0d lvl %0d/%0d",
                                 $realtime, want.status, got.status, want.res.ran_id,
                                 got.res.ran_id, want.res.ran_level, got.res.ran_level);
                        $display("  rem %0d/%0d pen %0d/%0d fin %0d/%0d mv %0d/%0d nxt %0d/%0d",
                                 want.res.remaining, got.res.remaining,
                                 want.res.penalty_after, got.res.penalty_after,
                                 want.res.finished, got.res.finished,
                                 want.res.moved, got.res.moved,
                                 want.res.next_level, got.res.next_level);
                        $display("  time %0d/%0d", want.res.time_now, got.res.time_now);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic add_req(input logic act, input logic [7:0] id, input logic [15:0] size);
        sched_req_t req;
        req.act  = act;
        req.id   = id;
        req.size = size;
        pending_q.push_back(req);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_config(input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] s2,
                              input logic [7:0] g, input logic [7:0] m0,
                              input logic [7:0] m1, input logic [7:0] m2);
        write_reg(CFG_SLICE0, s0);
        write_reg(CFG_SLICE1, s1);
        write_reg(CFG_SLICE2, s2);
        write_reg(CFG_GAIN, g);
        write_reg(CFG_MAXPEN0, m0);
        write_reg(CFG_MAXPEN1, m1);
        write_reg(CFG_MAXPEN2, m2);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // bursts biased toward arrivals or steps so the levels fill up and drain
    task automatic queue_random(input int n);
        int         left;
        int         burst;
        int         arrive_pct;
        int         r;
        logic [15:0] size;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(8, 40);
            r = $urandom_range(2);
            arrive_pct = (r == 0) ? 15 : (r == 1) ? 50 : 85;
            while (burst > 0 && left > 0) begin
                r = $urandom_range(99);
                if (r < 35) size = 16'($urandom_range(1, 16));
                else if (r < 75) size = 16'($urandom_range(1, 1200));
                else if (r < 95) size = 16'($urandom_range(1, 65535));
                else size = ($urandom_range(1) != 0) ? 16'hFFFF : 16'd1;
                add_req(($urandom_range(99) < arrive_pct) ? ACT_ARRIVE : ACT_STEP,
                        8'($urandom_range(255)), size);
                burst--;
                left--;
            end
        end
    endtask

    initial begin
        tx_idle_pct = 20;
        rx_idle_pct = 66;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // default config: idle step, field extremes, zero size, fill until refused
        @(posedge aclk);
        add_req(ACT_STEP, 8'h3C, 16'hFFFF);
        add_req(ACT_ARRIVE, 8'h00, 16'd1);
        add_req(ACT_ARRIVE, 8'hFF, 16'hFFFF);
        add_req(ACT_ARRIVE, 8'h5A, 16'd0);
        repeat (4) add_req(ACT_STEP, 8'($urandom_range(255)), 16'($urandom_range(65535)));
        for (int i = 0; i < 16; i++) begin
            add_req(ACT_ARRIVE, 8'(8'h10 + i), 16'(1 << i));
        end
        add_req(ACT_STEP, 8'h00, 16'h0000);
        queue_random(80);
        wait_drained();

        // settings of one: every run that does not finish moves on to the next level, level 2 wrapping to level 0
        set_config(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
        @(posedge aclk);
        queue_random(100);
        wait_drained();

        tx_idle_pct = 66;
        rx_idle_pct = 20;
        set_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        @(posedge aclk);
        queue_random(100);
        wait_drained();

        // zero slice, zero gain and zero limit
        set_config(8'd0, 8'd4, 8'd9, 8'd0, 8'd0, 8'd2, 8'd0);
        @(posedge aclk);
        queue_random(60);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(8'($urandom_range(1, 32)), 8'($urandom_range(1, 32)),
                   8'($urandom_range(1, 32)), 8'($urandom_range(1, 6)),
                   8'($urandom_range(1, 24)), 8'($urandom_range(1, 24)),
                   8'($urandom_range(1, 24)));
        @(posedge aclk);
        queue_random(130);
        wait_drained();

        set_config(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                   8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                   8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                   8'($urandom_range(1, 255)));
        @(posedge aclk);
        queue_random(130);
        wait_drained();

        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
